FILE: hdl/rhsl_pkg.sv
// Package for the RGB to HSL converter: payload types and conversion constants.
`timescale 1ns / 1ps

package rhsl_pkg;

	localparam int ChanW  = 8;
	localparam int HueW   = 9;

	// Number of restoring-division steps (one quotient bit each)
	localparam int DivSteps = 8;

	// Hue offsets per sector: 360 - 60 + 60*base, with base 0, 2, 4
	localparam logic [9:0] HueOfsRed   = 10'd300;
	localparam logic [9:0] HueOfsGreen = 10'd420;
	localparam logic [9:0] HueOfsBlue  = 10'd540;
	localparam logic [9:0] HueTurn     = 10'd360;

	// Full scale of saturation and lightness
	localparam logic [8:0] FullScale = 9'd255;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HueW-1:0]  hue;
		logic [ChanW-1:0] saturation;
		logic [ChanW-1:0] lightness;
	} hsl_t;

endpackage

FILE: hdl/rgb_to_hsl_pixel_converter.sv
// RGB to HSL converter top level: min/max, numerator setup, bit-per-stage dividers.
`timescale 1ns / 1ps

// One pixel enters on every clock (busy is never raised) and its HSL result
// appears on result with done high after these registered stages:
// one stage for max/min and hue sector, one for the division operands, eight
// stages of restoring division that resolve one quotient bit each for the
// saturation and hue quotients in parallel, and one output register. The
// receiver cannot stall, so every result must be taken in its done cycle.
module rgb_to_hsl_pixel_converter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  rhsl_pkg::pixel_t pixel,
	output logic            done,
	output rhsl_pkg::hsl_t  result
);
	import rhsl_pkg::*;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// Stage 1: max/min, sector and signed channel difference
	logic [7:0]        mx, mn;
	sector_t           sector;
	logic signed [8:0] diff;

	logic              valid_s1;
	logic [7:0]        d_s1;
	logic [8:0]        t_s1;
	sector_t           sector_s1;
	logic signed [8:0] diff_s1;

	always_comb begin
		mx = pixel.red;
		mn = pixel.red;
		if (pixel.green > mx) mx = pixel.green;
		if (pixel.blue > mx) mx = pixel.blue;
		if (pixel.green < mn) mn = pixel.green;
		if (pixel.blue < mn) mn = pixel.blue;
		// first channel equal to the max wins
		if (pixel.red == mx) begin
			sector = SEC_RED;
			diff   = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
		end else if (pixel.green == mx) begin
			sector = SEC_GREEN;
			diff   = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
		end else begin
			sector = SEC_BLUE;
			diff   = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
		end
	end

	always_ff @(posedge clk) begin
		d_s1      <= mx - mn;
		t_s1      <= {1'b0, mx} + {1'b0, mn};
		sector_s1 <= sector;
		diff_s1   <= diff;
	end

	// Stage 2: rounded-division operands, floor((2n + m) / (2m))
	logic [8:0]  sat_den;
	logic [8:0]  hue_span;
	logic [9:0]  light_sum;

	logic        valid_s2;
	logic [16:0] sat_num_s2;
	logic [8:0]  sat_den_s2;
	logic [16:0] hue_num_s2;
	logic [8:0]  hue_den_s2;
	logic        grey_s2;
	sector_t     sector_s2;
	logic [7:0]  light_s2;

	always_comb begin
		// denominator is t for dark pixels, 510 - t for light ones
		if (t_s1 <= FullScale) sat_den = t_s1;
		else                   sat_den = 9'(({1'b0, FullScale} << 1) - {1'b0, t_s1});
		// diff + d lies in 0..2d, so the hue numerator never goes negative
		hue_span  = 9'($signed(diff_s1) + $signed({1'b0, d_s1}));
		light_sum = {1'b0, t_s1} + 10'd1;
	end

	always_ff @(posedge clk) begin
		sat_num_s2 <= 17'(17'd510 * {9'd0, d_s1}) + {8'd0, sat_den};
		sat_den_s2 <= {sat_den[7:0], 1'b0};
		hue_num_s2 <= 17'(17'd120 * {8'd0, hue_span}) + {9'd0, d_s1};
		hue_den_s2 <= {d_s1, 1'b0};
		grey_s2    <= (d_s1 == 8'd0);
		sector_s2  <= sector_s1;
		light_s2   <= light_sum[8:1];
	end

	// Stages 3..10: restoring division, one quotient bit per stage.
	// Index k of each array is pipeline stage 2 + k.
	logic        div_valid_s [0:DivSteps];
	logic [16:0] sat_rem_s   [0:DivSteps];
	logic [7:0]  sat_quo_s   [0:DivSteps];
	logic [8:0]  sat_den_s   [0:DivSteps];
	logic [16:0] hue_rem_s   [0:DivSteps];
	logic [7:0]  hue_quo_s   [0:DivSteps];
	logic [8:0]  hue_den_s   [0:DivSteps];
	logic        grey_s      [0:DivSteps];
	sector_t     sector_s    [0:DivSteps];
	logic [7:0]  light_s     [0:DivSteps];

	assign div_valid_s[0] = valid_s2;
	assign sat_rem_s[0]   = sat_num_s2;
	assign sat_quo_s[0]   = 8'd0;
	assign sat_den_s[0]   = sat_den_s2;
	assign hue_rem_s[0]   = hue_num_s2;
	assign hue_quo_s[0]   = 8'd0;
	assign hue_den_s[0]   = hue_den_s2;
	assign grey_s[0]      = grey_s2;
	assign sector_s[0]    = sector_s2;
	assign light_s[0]     = light_s2;

	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		localparam int Sh = DivSteps - 1 - k;
		logic [16:0] sat_sub, hue_sub;
		logic        sat_ge, hue_ge;

		// trial subtract of the divisor aligned to this quotient bit
		always_comb begin
			sat_sub = 17'({8'd0, sat_den_s[k]} << Sh);
			hue_sub = 17'({8'd0, hue_den_s[k]} << Sh);
			sat_ge  = (sat_rem_s[k] >= sat_sub);
			hue_ge  = (hue_rem_s[k] >= hue_sub);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s[k+1] <= 1'b0;
			end else begin
				div_valid_s[k+1] <= div_valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sat_rem_s[k+1] <= sat_ge ? (sat_rem_s[k] - sat_sub) : sat_rem_s[k];
			sat_quo_s[k+1] <= {sat_quo_s[k][6:0], sat_ge};
			hue_rem_s[k+1] <= hue_ge ? (hue_rem_s[k] - hue_sub) : hue_rem_s[k];
			hue_quo_s[k+1] <= {hue_quo_s[k][6:0], hue_ge};
			sat_den_s[k+1] <= sat_den_s[k];
			hue_den_s[k+1] <= hue_den_s[k];
			grey_s[k+1]    <= grey_s[k];
			sector_s[k+1]  <= sector_s[k];
			light_s[k+1]   <= light_s[k];
		end
	end

	// Stage 11: sector offset, wrap into one turn, grey override
	logic [9:0] hue_ofs, hue_raw, hue_wrap;
	logic       done_q;
	hsl_t       result_q;

	always_comb begin
		case (sector_s[DivSteps])
			SEC_RED:   hue_ofs = HueOfsRed;
			SEC_GREEN: hue_ofs = HueOfsGreen;
			SEC_BLUE:  hue_ofs = HueOfsBlue;
			default:   hue_ofs = HueOfsRed;
		endcase
		hue_raw  = hue_ofs + {2'd0, hue_quo_s[DivSteps]};
		hue_wrap = (hue_raw >= HueTurn) ? (hue_raw - HueTurn) : hue_raw;
	end

	always_ff @(posedge clk) begin
		result_q.hue        <= grey_s[DivSteps] ? 9'd0 : hue_wrap[8:0];
		result_q.saturation <= grey_s[DivSteps] ? 8'd0 : sat_quo_s[DivSteps];
		result_q.lightness  <= light_s[DivSteps];
	end

	// Valid bits for the front stages and the output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			done_q   <= div_valid_s[DivSteps];
		end
	end

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: hdl/rhsl_checker.sv
// Port-level checker for the RGB to HSL converter, bound to the top level.
`timescale 1ns / 1ps

module rhsl_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input rhsl_pkg::pixel_t pixel,
	input logic             done,
	input rhsl_pkg::hsl_t   result
);
	import rhsl_pkg::*;

	localparam int Latency = 11;

	// The pipeline takes a pixel every cycle
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every transfer in yields a result a fixed time later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Latency done)
		else $error("result missing after start");

	// Hue stays within one turn
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hue < 9'd360))
		else $error("hue out of range");

	// Zero saturation only for grey, which also has zero hue
	a_sat_zero_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturation == 8'd0) |-> (result.hue == 9'd0))
		else $error("zero saturation with nonzero hue");

	// A grey pixel comes out with zero hue and saturation
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && pixel.red == pixel.green && pixel.green == pixel.blue)
		|-> ##Latency (result.saturation == 8'd0 && result.hue == 9'd0))
		else $error("grey pixel not grey");

endmodule

bind rgb_to_hsl_pixel_converter rhsl_checker u_rhsl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.pixel  (pixel),
	.done   (done),
	.result (result)
);

FILE: verif/testbench.sv
// Self-checking testbench for the RGB to HSL pixel converter.
`timescale 1ns / 1ps

module testbench;
	import rhsl_pkg::*;

	localparam int NumRandom   = 850;
	localparam int DrainCycles = 16;
	localparam int MaxPrinted  = 100;

	typedef struct {
		pixel_t px;
		bit     typed;
		hsl_t   want;
	} vector_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   start;
	logic   busy;
	pixel_t pixel;
	logic   done;
	hsl_t   result;

	hsl_t    pending_hsl[$];
	vector_t directed_rows[$];
	int      mismatch_count = 0;
	int      burst_left = 0;

	rgb_to_hsl_pixel_converter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.done(done),
		.result(result)
	);

	// 50 MHz clock
	always #10 clk = ~clk;

	// Expected HSL of one pixel; quotients rounded half up on integers
	function automatic hsl_t predict_hsl(pixel_t p);
		int unsigned hi, lo, span, total, den, sector, up, down, numer, deg;
		hsl_t r;
		hi = p.red;
		lo = p.red;
		if (p.green > hi) hi = p.green;
		if (p.blue > hi) hi = p.blue;
		if (p.green < lo) lo = p.green;
		if (p.blue < lo) lo = p.blue;
		span  = hi - lo;
		total = hi + lo;
		r.lightness  = 8'((total + 1) >> 1);
		r.saturation = '0;
		r.hue        = '0;
		if (span != 0) begin
			den = (total <= 255) ? total : 510 - total;
			r.saturation = 8'((2 * 255 * span + den) / (2 * den));
			// first channel equal to the max picks the sector
			if (p.red == hi) begin
				sector = 0; up = p.green; down = p.blue;
			end else if (p.green == hi) begin
				sector = 2; up = p.blue; down = p.red;
			end else begin
				sector = 4; up = p.red; down = p.green;
			end
			// one full turn added up front keeps the numerator positive
			numer = 60 * (sector * span + up) + 360 * span - 60 * down;
			deg = (2 * numer + span) / (2 * span);
			if (deg >= 360) deg -= 360;
			r.hue = 9'(deg);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		if (mismatch_count <= MaxPrinted)
			$display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic add_vector(int r, int g, int b, bit typed, int h, int s, int l);
		vector_t v;
		v.px    = '{red: 8'(r), green: 8'(g), blue: 8'(b)};
		v.typed = typed;
		v.want  = '{hue: 9'(h), saturation: 8'(s), lightness: 8'(l)};
		directed_rows.push_back(v);
	endtask

	// Channel value biased toward the ends of the range
	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(0, 3));
			3: return 8'($urandom_range(252, 255));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		logic [7:0] v;
		p = pixel_t'(24'($urandom));
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				p = '{red: pick_channel(), green: pick_channel(), blue: pick_channel()};
			end
			3, 4: begin
				v = 8'($urandom);
				p = '{red: v, green: v, blue: v};
			end
			// two equal channels, which may tie for the largest
			5, 6: p.green = p.red;
			7: p.blue = p.red;
			8: p.blue = p.green;
			// near grey, tiny span
			9, 10: begin
				v = 8'($urandom);
				p.green = v ^ 8'($urandom_range(0, 3));
				p.blue  = v ^ 8'($urandom_range(0, 3));
				p.red   = v;
			end
			default: ;
		endcase
		return p;
	endfunction

	// One transfer, then an idle gap at the end of each burst
	task automatic send_pixel(pixel_t p, hsl_t want);
		logic busy_seen;
		start <= 1'b1;
		pixel <= p;
		do begin
			@(negedge clk);
			busy_seen = busy;
			@(posedge clk);
		end while (busy_seen !== 1'b0);
		pending_hsl.push_back(want);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			pixel <= pixel_t'(24'($urandom));
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
		end
	endtask

	// Result check, sampled mid-cycle so outputs are settled
	always @(negedge clk) begin
		hsl_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_hsl.size() == 0) begin
				report_mismatch("unexpected result, hue", int'(result.hue), 0);
			end else begin
				want = pending_hsl.pop_front();
				if (result.hue !== want.hue)
					report_mismatch("hue", int'(result.hue), int'(want.hue));
				if (result.saturation !== want.saturation)
					report_mismatch("saturation", int'(result.saturation),
						int'(want.saturation));
				if (result.lightness !== want.lightness)
					report_mismatch("lightness", int'(result.lightness),
						int'(want.lightness));
			end
		end
	end

	// Stimulus
	initial begin
		pixel_t p;
		hsl_t   want;
		arst_n = 1'b0;
		start  = 1'b0;
		pixel  = '0;

		// greys, primaries, secondaries and single-step extremes
		add_vector(0, 0, 0, 1, 0, 0, 0);
		add_vector(255, 255, 255, 1, 0, 0, 255);
		add_vector(128, 128, 128, 1, 0, 0, 128);
		add_vector(127, 127, 127, 1, 0, 0, 127);
		add_vector(254, 254, 254, 1, 0, 0, 254);
		add_vector(255, 0, 0, 1, 0, 255, 128);
		add_vector(0, 255, 0, 1, 120, 255, 128);
		add_vector(0, 0, 255, 1, 240, 255, 128);
		add_vector(255, 255, 0, 1, 60, 255, 128);
		add_vector(0, 255, 255, 1, 180, 255, 128);
		add_vector(255, 0, 255, 1, 300, 255, 128);
		add_vector(1, 0, 0, 1, 0, 255, 1);
		// negative hue that rounds back to zero, then other rows checked against predict_hsl
		add_vector(255, 0, 1, 0, 0, 0, 0);
		add_vector(255, 1, 0, 0, 0, 0, 0);
		add_vector(255, 254, 254, 0, 0, 0, 0);
		add_vector(1, 1, 0, 0, 0, 0, 0);
		add_vector(0, 1, 1, 0, 0, 0, 0);
		add_vector(1, 0, 1, 0, 0, 0, 0);
		add_vector(0, 0, 1, 0, 0, 0, 0);
		add_vector(100, 50, 0, 0, 0, 0, 0);
		add_vector(255, 200, 100, 0, 0, 0, 0);
		add_vector(200, 255, 10, 0, 0, 0, 0);
		add_vector(10, 20, 230, 0, 0, 0, 0);
		add_vector(170, 85, 85, 0, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed rows
		foreach (directed_rows[i]) begin
			want = directed_rows[i].typed ? directed_rows[i].want
				: predict_hsl(directed_rows[i].px);
			send_pixel(directed_rows[i].px, want);
		end

		// random pixels
		repeat (NumRandom) begin
			p = random_pixel();
			send_pixel(p, predict_hsl(p));
		end
		start <= 1'b0;

		// drain the pipeline
		while (pending_hsl.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/rhsl_pkg.sv
hdl/rgb_to_hsl_pixel_converter.sv
hdl/rhsl_checker.sv
verif/testbench.sv
